### rtl/core/dpq_pkg.sv
// Shared types and constants of the drop pulse qualifier.
// Used by every module of the block except dpq_div; depends on nothing else.
`timescale 1ns / 1ps

package dpq_pkg;

  localparam int RING_DEPTH_DEF = 20;
  localparam logic [31:0] CAL_SPAN_MS = 32'd1000;
  localparam logic [31:0] WIDTH_MIN_US = 32'd300;
  localparam logic [31:0] WIDTH_MAX_US = 32'd100000;
  localparam logic [9:0] GAP_FLOOR_MS = 10'd200;
  localparam logic [9:0] GAP_CEIL_MS = 10'd800;

  typedef enum logic [1:0] {
    REQ_POLL  = 2'd0,
    REQ_EDGE  = 2'd1,
    REQ_CLEAR = 2'd2
  } req_kind_t;

  typedef enum logic [2:0] {
    EV_NONE      = 3'd0,
    EV_START     = 3'd1,
    EV_DROP      = 3'd2,
    EV_BAD_WIDTH = 3'd3,
    EV_TOO_CLOSE = 3'd4,
    EV_CALIBRATE = 3'd5
  } event_t;

  typedef enum logic [1:0] {
    CFG_MIN_GAP     = 2'd0,
    CFG_BLANK_END   = 2'd1,
    CFG_CALIB_BEGIN = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic [1:0]  req_type;
    logic        pin_level;
    logic [31:0] stamp_ms;
    logic [31:0] stamp_us;
  } req_t;

  typedef struct packed {
    logic [2:0]  event_code;
    logic        is_calibrated;
    logic        idle_high;
    logic [31:0] accepted_count;
    logic [31:0] rejected_count;
    logic [31:0] edge_count;
    logic [31:0] recent_interval_ms;
    logic [31:0] recent_drop_ms;
    logic [4:0]  stored_intervals;
    logic [31:0] mean_interval_ms;
    logic [31:0] median_interval_ms;
  } rsp_t;

  // Update order for the sorted copy of the ring.
  typedef struct packed {
    logic        remove;
    logic [31:0] old_val;
    logic [31:0] new_val;
  } sort_cmd_t;

endpackage

### rtl/core/dpq_div.sv
// Iterative restoring divider for the mean of the stored intervals.
// One quotient bit per cycle while busy; does not use dpq_pkg.
`timescale 1ns / 1ps

module dpq_div #(
  parameter int NUMW = 37,
  parameter int DENW = 5
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  logic [NUMW-1:0] num,
  input  logic [DENW-1:0] den,
  output logic            done,
  output logic [31:0]     quo
);

  localparam int STEPW = $clog2(NUMW + 1);

  logic [NUMW-1:0]  q;
  logic [DENW-1:0]  rem;
  logic [DENW-1:0]  dv;
  logic [STEPW-1:0] steps;
  logic             busy;
  logic [DENW:0]    rem_sh;
  logic [DENW:0]    rem_sub;

  assign rem_sh  = {rem, q[NUMW-1]};
  assign rem_sub = rem_sh - {1'b0, dv};
  assign quo     = q[31:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        steps <= STEPW'(NUMW);
        q <= num;
        rem <= '0;
        dv <= den;
      end else if (busy) begin
        if (rem_sh >= {1'b0, dv}) begin
          rem <= rem_sub[DENW-1:0];
          q <= {q[NUMW-2:0], 1'b1};
        end else begin
          rem <= rem_sh[DENW-1:0];
          q <= {q[NUMW-2:0], 1'b0};
        end
        steps <= steps - 1'b1;
        if (steps == STEPW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

### rtl/core/dpq_sort.sv
// Sorted copy of the interval ring in a one-port-read memory, kept in order
// by a remove pass and an insert pass, then read for the median. Uses dpq_pkg.
`timescale 1ns / 1ps

module dpq_sort #(
  parameter int DEPTH = 20
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  dpq_pkg::sort_cmd_t            cmd,
  input  logic [$clog2(DEPTH+1)-1:0]    count,
  output logic                          done,
  output logic [31:0]                   median
);
  import dpq_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  typedef enum logic [10:0] {
    S_IDLE   = 11'b00000000001,
    S_RM_RD  = 11'b00000000010,
    S_RM_CHK = 11'b00000000100,
    S_IN_RD  = 11'b00000001000,
    S_IN_CHK = 11'b00000010000,
    S_IN_LST = 11'b00000100000,
    S_MD_RD0 = 11'b00001000000,
    S_MD_CK0 = 11'b00010000000,
    S_MD_RD1 = 11'b00100000000,
    S_MD_CK1 = 11'b01000000000,
    S_SPARE  = 11'b10000000000
  } sort_state_t;

  sort_state_t st;
  logic [31:0] mem [DEPTH];
  logic [31:0] rd_data;
  logic [31:0] lo;
  logic [31:0] oldv;
  logic [31:0] newv;
  logic [CW-1:0] idx;
  logic [CW-1:0] wptr;
  logic [CW-1:0] cnt;
  logic          found;
  logic [CW-1:0] rd_addr;
  logic          we;
  logic [CW-1:0] wa;
  logic [31:0]   wd;
  logic [CW-1:0] half;
  logic [32:0]   pair_sum;

  assign half = cnt >> 1;
  assign pair_sum = {1'b0, lo} + {1'b0, rd_data};

  always_comb begin
    rd_addr = idx;
    we = 1'b0;
    wa = wptr;
    wd = rd_data;
    case (st)
      S_RM_CHK: begin
        if (found || rd_data != oldv) begin
          we = 1'b1;
        end
      end
      S_IN_CHK: begin
        we = 1'b1;
        wa = idx + 1'b1;
        wd = (rd_data > newv) ? rd_data : newv;
      end
      S_IN_LST: begin
        we = 1'b1;
        wa = '0;
        wd = newv;
      end
      S_MD_RD0: rd_addr = cnt[0] ? half : half - 1'b1;
      S_MD_RD1: rd_addr = half;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr[AW-1:0]];
    if (we) begin
      mem[wa[AW-1:0]] <= wd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= S_IDLE;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      case (st)
        S_IDLE: begin
          if (start) begin
            oldv <= cmd.old_val;
            newv <= cmd.new_val;
            cnt <= count;
            if (cmd.remove) begin
              idx <= '0;
              wptr <= '0;
              found <= 1'b0;
              st <= S_RM_RD;
            end else if (count == '0) begin
              st <= S_IN_LST;
            end else begin
              idx <= count - 1'b1;
              st <= S_IN_RD;
            end
          end
        end
        S_RM_RD: st <= S_RM_CHK;
        S_RM_CHK: begin
          if (!found && rd_data == oldv) begin
            found <= 1'b1;
          end else begin
            wptr <= wptr + 1'b1;
          end
          if (idx == cnt - 1'b1) begin
            cnt <= cnt - 1'b1;
            if (cnt == CW'(1)) begin
              st <= S_IN_LST;
            end else begin
              idx <= cnt - CW'(2);
              st <= S_IN_RD;
            end
          end else begin
            idx <= idx + 1'b1;
            st <= S_RM_RD;
          end
        end
        S_IN_RD: st <= S_IN_CHK;
        S_IN_CHK: begin
          if (rd_data > newv) begin
            if (idx == '0) begin
              st <= S_IN_LST;
            end else begin
              idx <= idx - 1'b1;
              st <= S_IN_RD;
            end
          end else begin
            cnt <= cnt + 1'b1;
            st <= S_MD_RD0;
          end
        end
        S_IN_LST: begin
          cnt <= cnt + 1'b1;
          st <= S_MD_RD0;
        end
        S_MD_RD0: st <= S_MD_CK0;
        S_MD_CK0: begin
          if (cnt[0]) begin
            median <= rd_data;
            done <= 1'b1;
            st <= S_IDLE;
          end else begin
            lo <= rd_data;
            st <= S_MD_RD1;
          end
        end
        S_MD_RD1: st <= S_MD_CK1;
        S_MD_CK1: begin
          median <= pair_sum[32:1];
          done <= 1'b1;
          st <= S_IDLE;
        end
        default: st <= S_IDLE;
      endcase
    end
  end

endmodule

### rtl/core/drop_pulse_qualifier.sv
// Drop pulse qualifier: qualifies optical drop sensor pulses and keeps
// interval statistics in an interval ring memory plus a sorted copy.
// An item that stores no interval goes straight to S_DONE, where its result waits
// while the output stalls. A drop that stores an interval passes through S_RING
// and S_OLD, then waits in S_WAIT until the sort passes and the divider are done,
// then goes to S_DONE. One item at a time. Synchronous reset.
`timescale 1ns / 1ps

module drop_pulse_qualifier #(
  parameter int RING_DEPTH = dpq_pkg::RING_DEPTH_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  dpq_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output dpq_pkg::rsp_t rsp,
  input  logic          cfg_we,
  input  logic [1:0]    cfg_index,
  input  logic [31:0]   cfg_data
);
  import dpq_pkg::*;

  localparam int AW = $clog2(RING_DEPTH);
  localparam int CW = $clog2(RING_DEPTH + 1);
  localparam int SUMW = 32 + CW;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_RING = 6'b000010,
    S_OLD  = 6'b000100,
    S_WAIT = 6'b001000,
    S_DONE = 6'b010000,
    S_SPR  = 6'b100000
  } top_state_t;

  top_state_t st;

  logic [9:0]  min_gap;
  logic [31:0] blank_end;
  logic [31:0] calib_begin;
  logic [9:0]  gap_cfg;

  logic        cal, prior, idle_bit, in_pulse;
  logic        cal_next, prior_next, idle_next, in_pulse_next;
  logic [31:0] high_tally, low_tally, begin_us, good, bad, edges, last_ms, last_gap;
  logic [31:0] high_next, low_next, begin_next, good_next, bad_next, edges_next;
  logic [31:0] last_ms_next, last_gap_next;
  logic [2:0]  code, code_next;
  logic        push, clr;
  logic [31:0] gap, width;
  logic        blanked;

  logic [31:0]   ring [RING_DEPTH];
  logic [31:0]   ring_old;
  logic [AW-1:0] slot;
  logic [CW-1:0] fill;
  logic [CW-1:0] fill_prev;
  logic          was_full;
  logic [31:0]   new_gap;
  logic [SUMW-1:0] sum;
  logic [SUMW-1:0] sum_next;
  logic [31:0]   mean, median;
  logic          sort_ok, div_ok;
  logic          sort_done, div_done;
  logic [31:0]   sort_median, div_quo;
  logic          start_units;
  sort_cmd_t     scmd;
  logic [CW+4:0] fill_ext;
  logic          accept;

  assign accept = req_valid && !req_stall;
  assign req_stall = (st != S_IDLE);
  assign gap_cfg = cfg_data[9:0];
  assign fill_ext = {5'b0, fill};

  // Configuration writes; minimum gap saturates into its legal range.
  always_ff @(posedge clk) begin
    if (rst) begin
      min_gap <= GAP_FLOOR_MS;
      blank_end <= '0;
      calib_begin <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_MIN_GAP: begin
          if (gap_cfg < GAP_FLOOR_MS) min_gap <= GAP_FLOOR_MS;
          else if (gap_cfg > GAP_CEIL_MS) min_gap <= GAP_CEIL_MS;
          else min_gap <= gap_cfg;
        end
        CFG_BLANK_END: blank_end <= cfg_data;
        CFG_CALIB_BEGIN: calib_begin <= cfg_data;
        default: ;
      endcase
    end
  end

  // Per-item qualification of the scalar state.
  always_comb begin
    cal_next = cal;
    prior_next = prior;
    idle_next = idle_bit;
    in_pulse_next = in_pulse;
    high_next = high_tally;
    low_next = low_tally;
    begin_next = begin_us;
    good_next = good;
    bad_next = bad;
    edges_next = edges;
    last_ms_next = last_ms;
    last_gap_next = last_gap;
    code_next = EV_NONE;
    push = 1'b0;
    clr = 1'b0;
    blanked = ((req.stamp_ms - blank_end) >> 31) != 32'd0;
    gap = req.stamp_ms - last_ms;
    width = req.stamp_us - begin_us;
    case (req.req_type)
      REQ_POLL: begin
        if (blanked) begin
          prior_next = req.pin_level;
          in_pulse_next = 1'b0;
        end else if (!cal) begin
          if (req.pin_level) high_next = high_tally + 1'b1;
          else low_next = low_tally + 1'b1;
          if ((req.stamp_ms - calib_begin) >= CAL_SPAN_MS) begin
            idle_next = (high_next >= low_next);
            prior_next = req.pin_level;
            cal_next = 1'b1;
            code_next = EV_CALIBRATE;
          end
        end
      end
      REQ_EDGE: begin
        if (!cal || blanked) begin
          prior_next = req.pin_level;
          in_pulse_next = 1'b0;
        end else if (req.pin_level != prior) begin
          edges_next = edges + 1'b1;
          prior_next = req.pin_level;
          if (req.pin_level != idle_bit) begin
            in_pulse_next = 1'b1;
            begin_next = req.stamp_us;
            code_next = EV_START;
          end else if (in_pulse) begin
            in_pulse_next = 1'b0;
            if (width >= WIDTH_MIN_US && width <= WIDTH_MAX_US) begin
              if (last_ms != '0 && gap < {22'd0, min_gap}) begin
                bad_next = bad + 1'b1;
                code_next = EV_TOO_CLOSE;
              end else begin
                good_next = good + 1'b1;
                if (last_ms != '0) begin
                  last_gap_next = gap;
                  push = 1'b1;
                end
                last_ms_next = req.stamp_ms;
                code_next = EV_DROP;
              end
            end else begin
              bad_next = bad + 1'b1;
              code_next = EV_BAD_WIDTH;
            end
          end
        end
      end
      REQ_CLEAR: begin
        clr = 1'b1;
        good_next = '0;
        bad_next = '0;
        edges_next = '0;
        last_ms_next = '0;
        last_gap_next = '0;
      end
      default: ;
    endcase
  end

  assign sum_next = sum + {{CW{1'b0}}, new_gap} - (was_full ? {{CW{1'b0}}, ring_old} : '0);
  assign start_units = (st == S_OLD);
  assign scmd = '{remove: was_full, old_val: ring_old, new_val: new_gap};

  // Interval ring: old entry is read out as the new one is written.
  always_ff @(posedge clk) begin
    if (st == S_RING) begin
      ring_old <= ring[slot];
      ring[slot] <= new_gap;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= S_IDLE;
      cal <= 1'b0;
      prior <= 1'b0;
      idle_bit <= 1'b0;
      in_pulse <= 1'b0;
      high_tally <= '0;
      low_tally <= '0;
      begin_us <= '0;
      good <= '0;
      bad <= '0;
      edges <= '0;
      last_ms <= '0;
      last_gap <= '0;
      fill <= '0;
      slot <= '0;
      sum <= '0;
      mean <= '0;
      median <= '0;
      rsp_valid <= 1'b0;
      sort_ok <= 1'b0;
      div_ok <= 1'b0;
    end else begin
      if (st == S_DONE && (!rsp_valid || !rsp_stall)) rsp_valid <= 1'b1;
      else if (rsp_valid && !rsp_stall) rsp_valid <= 1'b0;
      if (st == S_OLD) begin
        sort_ok <= 1'b0;
        div_ok <= 1'b0;
      end else begin
        if (sort_done) sort_ok <= 1'b1;
        if (div_done) div_ok <= 1'b1;
      end
      case (st)
        S_IDLE: begin
          if (accept) begin
            cal <= cal_next;
            prior <= prior_next;
            idle_bit <= idle_next;
            in_pulse <= in_pulse_next;
            high_tally <= high_next;
            low_tally <= low_next;
            begin_us <= begin_next;
            good <= good_next;
            bad <= bad_next;
            edges <= edges_next;
            last_ms <= last_ms_next;
            last_gap <= last_gap_next;
            code <= code_next;
            new_gap <= gap;
            if (clr) begin
              fill <= '0;
              slot <= '0;
              sum <= '0;
              mean <= '0;
              median <= '0;
            end
            st <= push ? S_RING : S_DONE;
          end
        end
        S_RING: begin
          fill_prev <= fill;
          was_full <= (fill == CW'(RING_DEPTH));
          if (fill != CW'(RING_DEPTH)) fill <= fill + 1'b1;
          slot <= (slot == AW'(RING_DEPTH - 1)) ? '0 : slot + 1'b1;
          st <= S_OLD;
        end
        S_OLD: begin
          sum <= sum_next;
          st <= S_WAIT;
        end
        S_WAIT: begin
          if (sort_ok && div_ok) begin
            mean <= div_quo;
            median <= sort_median;
            st <= S_DONE;
          end
        end
        S_DONE: begin
          if (!rsp_valid || !rsp_stall) begin
            rsp.event_code <= code;
            rsp.is_calibrated <= cal;
            rsp.idle_high <= idle_bit;
            rsp.accepted_count <= good;
            rsp.rejected_count <= bad;
            rsp.edge_count <= edges;
            rsp.recent_interval_ms <= last_gap;
            rsp.recent_drop_ms <= last_ms;
            rsp.stored_intervals <= fill_ext[4:0];
            rsp.mean_interval_ms <= mean;
            rsp.median_interval_ms <= median;
            st <= S_IDLE;
          end
        end
        default: st <= S_IDLE;
      endcase
    end
  end

  dpq_sort #(.DEPTH(RING_DEPTH)) u_sort (
    .clk    (clk),
    .rst    (rst),
    .start  (start_units),
    .cmd    (scmd),
    .count  (fill_prev),
    .done   (sort_done),
    .median (sort_median)
  );

  dpq_div #(.NUMW(SUMW), .DENW(CW)) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (start_units),
    .num   (sum_next),
    .den   (fill),
    .done  (div_done),
    .quo   (div_quo)
  );

endmodule

### rtl/core/dpq_checker.sv
// Port-level checks for drop_pulse_qualifier, attached by the bind below.
// Depends on dpq_pkg and the top level's ports.
`timescale 1ns / 1ps

module dpq_checker (
  input logic          clk,
  input logic          rst,
  input logic          req_valid,
  input logic          req_stall,
  input dpq_pkg::req_t req,
  input logic          rsp_valid,
  input logic          rsp_stall,
  input dpq_pkg::rsp_t rsp
);
  import dpq_pkg::*;

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_stall |=> req_stall)
    else $error("block took a second beat while busy");

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
    else $error("stalled result beat changed");

  a_empty_stats: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.stored_intervals == 5'd0 |->
      rsp.mean_interval_ms == 32'd0 && rsp.median_interval_ms == 32'd0)
    else $error("statistics nonzero with an empty ring");

  a_uncal_quiet: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp.is_calibrated |->
      rsp.edge_count == 32'd0 && rsp.accepted_count == 32'd0 && !rsp.idle_high)
    else $error("pulse activity before calibration");

endmodule

bind drop_pulse_qualifier dpq_checker u_dpq_checker (.*);

### tb/drop_pulse_qualifier_chk.sv
// Checker for the drop pulse qualifier: watches the request and response beats,
// keeps its own model of the qualifier state and compares every response.
// Depends on dpq_pkg.
`timescale 1ns / 1ps

module drop_pulse_qualifier_chk (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  input  logic          req_stall,
  input  dpq_pkg::req_t req,
  input  logic          rsp_valid,
  input  logic          rsp_stall,
  input  dpq_pkg::rsp_t rsp,
  input  logic          cfg_we,
  input  logic [1:0]    cfg_index,
  input  logic [31:0]   cfg_data,
  output int            fail_count,
  output int            pending
);
  import dpq_pkg::*;

  localparam int DEPTH = RING_DEPTH_DEF;

  logic [9:0]  gap_min;
  logic [31:0] blank_end, cal_begin;
  logic        cal_done, last_level, idle_lvl, pulse_open;
  logic [31:0] n_high, n_low, pulse_t0, n_good, n_bad, n_edges, drop_t, drop_gap;
  logic [31:0] gaps [DEPTH];
  int          fill, slot;
  rsp_t        expected_rsp [$];

  function automatic logic blanked(logic [31:0] ms);
    logic [31:0] d;
    d = ms - blank_end;
    return d[31];
  endfunction

  function automatic logic [31:0] gap_mean();
    logic [63:0] acc;
    acc = 0;
    if (fill == 0) return 0;
    for (int i = 0; i < fill; i++) acc += gaps[i];
    return 32'(acc / fill);
  endfunction

  function automatic logic [31:0] gap_median();
    logic [31:0] s [$];
    logic [32:0] pair;
    if (fill == 0) return 0;
    for (int i = 0; i < fill; i++) s.push_back(gaps[i]);
    s.sort();
    if (fill % 2 == 1) return s[fill / 2];
    pair = {1'b0, s[fill / 2 - 1]} + {1'b0, s[fill / 2]};
    return pair[32:1];
  endfunction

  task automatic wipe_stats();
    n_good = 0; n_bad = 0; n_edges = 0; drop_t = 0; drop_gap = 0; fill = 0; slot = 0;
  endtask

  task automatic qualify(req_t r);
    event_t ev;
    rsp_t o;
    logic [31:0] width, gap;
    ev = EV_NONE;
    case (r.req_type)
      REQ_POLL: begin
        if (blanked(r.stamp_ms)) begin
          last_level = r.pin_level;
          pulse_open = 0;
        end else if (!cal_done) begin
          if (r.pin_level) n_high++; else n_low++;
          if (r.stamp_ms - cal_begin >= CAL_SPAN_MS) begin
            idle_lvl = n_high >= n_low;
            last_level = r.pin_level;
            cal_done = 1;
            ev = EV_CALIBRATE;
          end
        end
      end
      REQ_EDGE: begin
        if (!cal_done || blanked(r.stamp_ms)) begin
          last_level = r.pin_level;
          pulse_open = 0;
        end else if (r.pin_level != last_level) begin
          n_edges++;
          if (r.pin_level != idle_lvl) begin
            pulse_open = 1;
            pulse_t0 = r.stamp_us;
            ev = EV_START;
          end else if (pulse_open) begin
            width = r.stamp_us - pulse_t0;
            pulse_open = 0;
            if (width >= WIDTH_MIN_US && width <= WIDTH_MAX_US) begin
              gap = r.stamp_ms - drop_t;
              if (drop_t != 0 && gap < {22'd0, gap_min}) begin
                n_bad++;
                ev = EV_TOO_CLOSE;
              end else begin
                n_good++;
                if (drop_t != 0) begin
                  drop_gap = gap;
                  gaps[slot] = gap;
                  slot = (slot + 1) % DEPTH;
                  if (fill < DEPTH) fill++;
                end
                drop_t = r.stamp_ms;
                ev = EV_DROP;
              end
            end else begin
              n_bad++;
              ev = EV_BAD_WIDTH;
            end
          end
          last_level = r.pin_level;
        end
      end
      REQ_CLEAR: wipe_stats();
      default: ;
    endcase
    o.event_code = ev;
    o.is_calibrated = cal_done;
    o.idle_high = idle_lvl;
    o.accepted_count = n_good;
    o.rejected_count = n_bad;
    o.edge_count = n_edges;
    o.recent_interval_ms = drop_gap;
    o.recent_drop_ms = drop_t;
    o.stored_intervals = 5'(fill);
    o.mean_interval_ms = gap_mean();
    o.median_interval_ms = gap_median();
    expected_rsp.push_back(o);
  endtask

  task automatic flag(string what, logic [31:0] exp_v, logic [31:0] act_v);
    fail_count++;
    if (fail_count <= 10)
      $display("mismatch %s: expected %0d actual %0d at %0t", what, exp_v, act_v, $realtime);
  endtask

  always @(posedge clk) begin
    rsp_t e;
    logic [31:0] v;
    if (rst) begin
      gap_min = GAP_FLOOR_MS; blank_end = 0; cal_begin = 0;
      cal_done = 0; last_level = 0; idle_lvl = 0; pulse_open = 0;
      n_high = 0; n_low = 0; pulse_t0 = 0;
      wipe_stats();
      expected_rsp.delete();
      fail_count = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_MIN_GAP: begin
            v = {22'd0, cfg_data[9:0]};
            if (v < GAP_FLOOR_MS) v = GAP_FLOOR_MS;
            if (v > GAP_CEIL_MS) v = GAP_CEIL_MS;
            gap_min = v[9:0];
          end
          CFG_BLANK_END:   blank_end = cfg_data;
          CFG_CALIB_BEGIN: cal_begin = cfg_data;
          default: ;
        endcase
      end
      if (req_valid && !req_stall) qualify(req);
      if (rsp_valid && !rsp_stall) begin
        if (expected_rsp.size() == 0) begin
          flag("unexpected beat", 0, 1);
        end else begin
          e = expected_rsp.pop_front();
          if (rsp.event_code != e.event_code) flag("event_code", e.event_code, rsp.event_code);
          if (rsp.is_calibrated != e.is_calibrated)
            flag("is_calibrated", e.is_calibrated, rsp.is_calibrated);
          if (rsp.idle_high != e.idle_high) flag("idle_high", e.idle_high, rsp.idle_high);
          if (rsp.accepted_count != e.accepted_count)
            flag("accepted_count", e.accepted_count, rsp.accepted_count);
          if (rsp.rejected_count != e.rejected_count)
            flag("rejected_count", e.rejected_count, rsp.rejected_count);
          if (rsp.edge_count != e.edge_count) flag("edge_count", e.edge_count, rsp.edge_count);
          if (rsp.recent_interval_ms != e.recent_interval_ms)
            flag("recent_interval_ms", e.recent_interval_ms, rsp.recent_interval_ms);
          if (rsp.recent_drop_ms != e.recent_drop_ms)
            flag("recent_drop_ms", e.recent_drop_ms, rsp.recent_drop_ms);
          if (rsp.stored_intervals != e.stored_intervals)
            flag("stored_intervals", e.stored_intervals, rsp.stored_intervals);
          if (rsp.mean_interval_ms != e.mean_interval_ms)
            flag("mean_interval_ms", e.mean_interval_ms, rsp.mean_interval_ms);
          if (rsp.median_interval_ms != e.median_interval_ms)
            flag("median_interval_ms", e.median_interval_ms, rsp.median_interval_ms);
        end
      end
    end
    pending = expected_rsp.size();
  end
endmodule

### tb/drop_pulse_qualifier_tb.sv
// Testbench top for the drop pulse qualifier: clock, reset, register writes,
// stimulus and the verdict. Depends on dpq_pkg, the block and the checker.
`timescale 1ns / 1ps

module drop_pulse_qualifier_tb;
  import dpq_pkg::*;

  logic        clk, rst;
  logic        req_valid, req_stall, rsp_valid, rsp_stall;
  req_t        req;
  rsp_t        rsp;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [31:0] cfg_data;
  int          fail_count, pending;
  logic        quiet;         // no idling in the last part of the run
  int          idle_cycles;
  logic [31:0] now_ms, now_us;
  logic        level_now;

  drop_pulse_qualifier uut (
    .clk(clk), .rst(rst), .req_valid(req_valid), .req_stall(req_stall), .req(req),
    .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  drop_pulse_qualifier_chk chk (
    .clk(clk), .rst(rst), .req_valid(req_valid), .req_stall(req_stall), .req(req),
    .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .fail_count(fail_count), .pending(pending)
  );

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  // Receiver stalls in bursts.
  initial begin
    int n;
    rsp_stall = 0;
    forever begin
      @(negedge clk);
      if (!quiet && $urandom_range(0, 7) == 0) begin
        n = $urandom_range(1, 9);
        rsp_stall <= 1;
        repeat (n) @(negedge clk);
        rsp_stall <= 0;
      end
    end
  end

  // Watchdog on cycles without any accepted beat.
  initial begin
    idle_cycles = 0;
    forever begin
      @(posedge clk);
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || rst) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles > 5000) begin
        $display("FAIL drop_pulse_qualifier");
        $finish;
      end
    end
  end

  // Returns at the accepting edge; the block stalls the next edge, so the
  // following negedge either clears valid or drives the next beat.
  task automatic send(logic [1:0] kind, logic lvl, logic [31:0] ms, logic [31:0] us);
    int n;
    @(negedge clk);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      n = $urandom_range(1, 9);
      req_valid <= 0;
      repeat (n) @(negedge clk);
    end
    req <= {kind, lvl, ms, us};
    req_valid <= 1;
    @(posedge clk);
    while (req_stall) @(posedge clk);
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [31:0] val);
    @(negedge clk);
    req_valid <= 0;
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 0;
  endtask

  task automatic drain();
    @(negedge clk);
    req_valid <= 0;
    while (pending != 0) @(posedge clk);
    repeat (120) @(negedge clk);
  endtask

  // Four polls across the calibration span, advancing the ms clock.
  task automatic calibrate(logic idle_lvl);
    for (int i = 0; i < 4; i++) begin
      send(REQ_POLL, (i == 3) ? ~idle_lvl : idle_lvl, now_ms, now_us);
      now_ms += 400;
      now_us += 400000;
    end
    level_now = idle_lvl;
  endtask

  // One pulse: leave idle then return, widths mostly in range.
  task automatic pulse(logic idle_lvl);
    logic [31:0] w;
    int pick;
    pick = $urandom_range(0, 9);
    w = (pick == 0) ? $urandom_range(0, 299) :
        (pick == 1) ? $urandom_range(100001, 200000) : $urandom_range(300, 100000);
    send(REQ_EDGE, ~idle_lvl, now_ms, now_us);
    now_us += w;
    now_ms += w / 1000;
    send(REQ_EDGE, idle_lvl, now_ms, now_us);
    now_ms += $urandom_range(0, 3) == 0 ? $urandom_range(0, 300) : $urandom_range(150, 2000);
    now_us = now_us + $urandom_range(1000, 500000);
  endtask

  initial begin
    logic idle_lvl;
    rst = 1; quiet = 0;
    req_valid = 0; req = '0;
    cfg_we = 0; cfg_index = CFG_MIN_GAP; cfg_data = 0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 0;

    // Directed: registers at extremes, field extremes, all request kinds.
    write_reg(CFG_MIN_GAP, 32'h3FF);
    write_reg(CFG_BLANK_END, 32'd100);
    write_reg(CFG_CALIB_BEGIN, 32'd0);
    send(REQ_POLL, 1, 32'd50, 32'hFFFF_FFFF);           // blanked poll
    send(REQ_EDGE, 1, 32'd60, 32'd0);                   // blanked edge
    send(REQ_EDGE, 0, 32'd200, 32'd0);                  // edge before calibration
    send(REQ_POLL, 1, 32'd300, 32'd0);
    send(REQ_POLL, 0, 32'd400, 32'd0);                  // counts tied, calibration span not yet over
    send(REQ_POLL, 0, 32'd1000, 32'd0);
    send(2'd3, 1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);        // unknown kind
    send(REQ_POLL, 1, 32'd1200, 32'd0);                 // poll after calibration
    send(REQ_EDGE, 0, 32'd0, 32'd0);                    // blanked edge at zero ms
    send(REQ_EDGE, 1, 32'd0, 32'd500);
    send(REQ_EDGE, 1, 32'd10, 32'd600);                 // unchanged level
    send(REQ_EDGE, 0, 32'd2000, 32'd1000);
    send(REQ_EDGE, 1, 32'd2000, 32'd1300);
    send(REQ_EDGE, 0, 32'd2100, 32'd2000);
    send(REQ_EDGE, 1, 32'd2100, 32'd2000);              // pulse start at the same ms
    send(REQ_EDGE, 1, 32'd2200, 32'd2000);
    send(REQ_EDGE, 0, 32'd2500, 32'd2299);
    send(REQ_EDGE, 1, 32'd2500, 32'd102300);            // pulse start
    send(REQ_EDGE, 1, 32'hFFFF_FFFF, 32'd0);
    send(REQ_CLEAR, 0, 32'd0, 32'd0);
    drain();

    // Random phases with different register settings.
    for (int ph = 0; ph < 6; ph++) begin
      write_reg(CFG_MIN_GAP, (ph == 0) ? 32'd0 : (ph == 1) ? 32'd800 : $urandom);
      now_ms = (ph == 2) ? 32'hFFFF_F000 : $urandom;
      now_us = $urandom;
      write_reg(CFG_CALIB_BEGIN, now_ms);
      write_reg(CFG_BLANK_END, (ph == 3) ? now_ms + 600 : now_ms - $urandom_range(0, 1000));
      if (ph == 5) quiet = 1;
      send(REQ_CLEAR, 0, now_ms, now_us);
      idle_lvl = $urandom_range(0, 1);
      calibrate(idle_lvl);
      for (int k = 0; k < 45; k++) begin
        case ($urandom_range(0, 19))
          0: send(REQ_CLEAR, $urandom_range(0, 1), $urandom, $urandom);
          1: send($urandom_range(0, 3), $urandom_range(0, 1), $urandom, $urandom);
          2: send(REQ_EDGE, idle_lvl, now_ms, now_us);
          default: pulse(idle_lvl);
        endcase
      end
      drain();
      // Clear leaves the calibration in place and only reset undoes it, so later
      // phases do not recalibrate: the block keeps its first idle level, and the
      // later phases just exercise edges, whatever idle level they pick.
    end

    drain();
    if (fail_count == 0) $display("PASS drop_pulse_qualifier");
    else $display("FAIL drop_pulse_qualifier");
    $finish;
  end
endmodule
